@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define CMA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define CMA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cma_pkg.sv @@
// ---------------------------------------------------------------------------
// cma_pkg
// Types, widths and codes for the centered moving average block.
// ---------------------------------------------------------------------------
`default_nettype none

package cma_pkg;

  localparam int MAX_HALF_WIDTH = 16;
  localparam int RING_DEPTH     = 2 * MAX_HALF_WIDTH + 1;
  localparam int SLOT_W         = $clog2(RING_DEPTH);
  localparam int CNT_W          = $clog2(RING_DEPTH + 1);
  localparam int HW_W           = 5;
  localparam int SAMPLE_W       = 16;
  localparam int AVG_W          = 24;
  localparam int WGT_W          = $clog2(MAX_HALF_WIDTH + 2);
  localparam int FRAC_SHIFT     = 9;   // 2 * 256: rounding doubles both sides
  // largest weight sum is the triangular one, (h + 1) squared
  localparam int WSUM_W         = $clog2((MAX_HALF_WIDTH + 1) * (MAX_HALF_WIDTH + 1) + 1);
  localparam int ACC_W          = SAMPLE_W + WSUM_W + 1;
  localparam int NUM_W          = ACC_W - 1 + FRAC_SHIFT;
  localparam int DEN_W          = WSUM_W + 1;
  localparam int DIV_CNT_W      = $clog2(NUM_W + 1);

  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED_MODE = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_EMIT
  } cma_state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } cma_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } cma_div_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/cma_in_if.sv @@
// ---------------------------------------------------------------------------
// cma_in_if
// Sample channel: one record sample per item, with end-of-record flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface cma_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cma_pkg::SAMPLE_W-1:0] sample;
  logic                                last_in;

  modport source (output valid, output sample, output last_in, input ready);
  modport sink   (input valid, input sample, input last_in, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cma_out_if.sv @@
// ---------------------------------------------------------------------------
// cma_out_if
// Result channel: one window average per item, with end-of-record flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface cma_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cma_pkg::AVG_W-1:0] average;
  logic                             last_out;

  modport source (output valid, output average, output last_out, input ready);
  modport sink   (input valid, input average, input last_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cma_cfg_if.sv @@
// ---------------------------------------------------------------------------
// cma_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface cma_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cma_pkg::CFG_IDX_W-1:0]      index;
  logic [cma_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cma_div.sv @@
// ---------------------------------------------------------------------------
// cma_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module cma_div (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  cma_pkg::cma_div_req_t req_i,
  output cma_pkg::cma_div_rsp_t rsp_o
);
  import cma_pkg::*;

  logic [NUM_W-1:0]     num_q;
  logic [DEN_W-1:0]     den_q;
  logic [DEN_W-1:0]     rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DEN_W:0]       trial;
  logic                 fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift into the numerator register from the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

`default_nettype wire

@@ hw/rtl/centered_moving_average.sv @@
// ---------------------------------------------------------------------------
// centered_moving_average
// Centered moving average over a record of samples, equal or triangular
// weights, window cut at the record ends, 8 fraction bits, rounded.
// ---------------------------------------------------------------------------
//
//  channel     dir  handshake        payload
//  in_chan_i   in   valid / ready    sample[15:0] signed, last_in
//  out_chan_o  out  valid / ready    average[23:0] signed, last_out
//  cfg_chan_i  in   valid / ready    index[3:0], data[7:0]
//
//  An item that causes no result is taken while the block stays idle. Each result
//  passes set-up, a sweep of n + 1 window entries (at most 33) at one ring read
//  per cycle, drain, divider load, the 34-step divider and hand-over.
//  Input waits while an item is worked; a result unclaimed in the output
//  register stalls only the next hand-over. Reset clears control and settings.
//
`default_nettype none
`include "assert_macros.svh"

module centered_moving_average (
  input  wire  clk_i,
  input  wire  rst_ni,
  cma_in_if.sink    in_chan_i,
  cma_out_if.source out_chan_o,
  cma_cfg_if.sink   cfg_chan_i
);
  import cma_pkg::*;

  // ---- configuration ------------------------------------------------------
  logic [HW_W-1:0] hw_q;
  logic            weighted_q;
  logic [HW_W-1:0] h_eff;
  logic            cfg_write;

  assign cfg_chan_i.ready = 1'b1;
  assign cfg_write = cfg_chan_i.valid && cfg_chan_i.ready;
  assign h_eff = (hw_q > HW_W'(MAX_HALF_WIDTH)) ? HW_W'(MAX_HALF_WIDTH) : hw_q;

  // ---- record state -------------------------------------------------------
  logic [CNT_W-1:0]  seen_q;
  logic [SLOT_W-1:0] wp_q;

  // ---- per-item working registers -----------------------------------------
  cma_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cur_q;      // record index of newest sample (saturated)
  logic [SLOT_W-1:0] newest_q;   // ring slot of newest sample
  logic              last_q;
  logic [HW_W-1:0]   h_q;
  logic [HW_W-1:0]   d_q;        // distance back from newest of the position

  // ---- window sweep -------------------------------------------------------
  logic [SLOT_W-1:0] n_q;        // last sweep index
  logic [SLOT_W-1:0] j_q;        // sweep index, distance back from newest
  logic [SLOT_W-1:0] slot_q;
  logic              pv_q;       // read data valid for accumulation
  logic [WGT_W-1:0]  w_q;
  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [WSUM_W-1:0]          wsum_q;
  logic                       neg_q;

  logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];

  // ---- output register ----------------------------------------------------
  logic                    out_valid_q;
  logic signed [AVG_W-1:0] avg_q;
  logic                    last_out_q;

  // ---- control ------------------------------------------------------------
  logic in_accept;
  logic out_free;
  logic emit_load;
  logic has_first;
  logic more_flush;

  cma_div_req_t div_req;
  cma_div_rsp_t div_rsp;

  assign in_chan_i.ready = (state_q == ST_IDLE);
  assign in_accept = in_chan_i.valid && in_chan_i.ready;
  assign out_free  = !out_valid_q || out_chan_o.ready;

  // A result is due at once when the sample h positions to the right is in,
  // or on the final sample, which flushes everything still open.
  assign has_first  = (seen_q >= {1'b0, h_eff}) || in_chan_i.last_in;
  assign more_flush = last_q && (d_q != '0);

  always_comb begin
    state_d   = state_q;
    emit_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && has_first) state_d = ST_SETUP;
      end
      ST_SETUP:    state_d = ST_MAC;
      ST_MAC: begin
        if (j_q == n_q) state_d = ST_DRAIN;
      end
      ST_DRAIN:    state_d = ST_DIV_LOAD;
      ST_DIV_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_load = 1'b1;
          state_d   = more_flush ? ST_SETUP : ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- config and record bookkeeping --------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q       <= HW_W'(2);
      weighted_q <= 1'b0;
      seen_q     <= '0;
      wp_q       <= '0;
    end else begin
      if (in_accept) begin
        if (in_chan_i.last_in) begin
          seen_q <= '0;
          wp_q   <= '0;
        end else begin
          seen_q <= (seen_q == CNT_W'(RING_DEPTH)) ? seen_q : seen_q + 1'b1;
          wp_q   <= (wp_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        end
      end
      if (cfg_write) begin
        unique case (cfg_chan_i.index)
          CFG_HALF_WIDTH: begin
            hw_q   <= cfg_chan_i.data[HW_W-1:0];
            seen_q <= '0;
            wp_q   <= '0;
          end
          CFG_WEIGHTED_MODE: weighted_q <= cfg_chan_i.data[0];
          default: ;
        endcase
      end
    end
  end

  // ---- ring memory: one write per item, one registered read per sweep cycle
  always_ff @(posedge clk_i) begin
    if (in_accept) ring_mem[wp_q] <= in_chan_i.sample;
    if (state_q == ST_MAC) rd_data_q <= ring_mem[slot_q];
  end

  // ---- sweep datapath -----------------------------------------------------
  logic [CNT_W-1:0]   pos_gap;
  logic [HW_W-1:0]    left;
  logic [SLOT_W-1:0]  gap;
  logic [SLOT_W-1:0]  tri_w;
  logic [WGT_W-1:0]   w_now;
  logic signed [WGT_W+SAMPLE_W:0] prod;
  logic [ACC_W-1:0]   acc_mag;

  // Left reach is cut at the record start: cur - d samples lie before p.
  assign pos_gap = cur_q - CNT_W'(d_q);
  assign left    = (pos_gap > CNT_W'(h_q)) ? h_q : pos_gap[HW_W-1:0];

  // Slot j back from newest sits at distance |d - j| from the position
  assign gap   = (SLOT_W'(d_q) > j_q) ? SLOT_W'(d_q) - j_q : j_q - SLOT_W'(d_q);
  assign tri_w = SLOT_W'(h_q) + 1'b1 - gap;
  assign w_now = weighted_q ? tri_w[WGT_W-1:0] : WGT_W'(1);

  assign prod    = $signed({1'b0, w_q}) * rd_data_q;
  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= (state_q == ST_MAC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cur_q    <= seen_q;
      newest_q <= wp_q;
      last_q   <= in_chan_i.last_in;
      h_q      <= h_eff;
      d_q      <= (seen_q >= {1'b0, h_eff}) ? h_eff : seen_q[HW_W-1:0];
    end
    if (state_q == ST_SETUP) begin
      n_q    <= SLOT_W'(d_q) + SLOT_W'(left);
      j_q    <= '0;
      slot_q <= newest_q;
      acc_q  <= '0;
      wsum_q <= '0;
    end
    if (state_q == ST_MAC) begin
      w_q    <= w_now;
      j_q    <= j_q + 1'b1;
      slot_q <= (slot_q == '0) ? SLOT_W'(RING_DEPTH - 1) : slot_q - 1'b1;
    end
    if (pv_q) begin
      acc_q  <= acc_q + ACC_W'(prod);
      wsum_q <= wsum_q + WSUM_W'(w_q);
    end
    if (state_q == ST_DIV_LOAD) neg_q <= acc_q[ACC_W-1];
    if (emit_load && more_flush) d_q <= d_q - 1'b1;
  end

  // ---- rounding divide: (512*|acc| + wsum) / (2*wsum) ---------------------
  assign div_req.start = (state_q == ST_DIV_LOAD);
  assign div_req.num   = (NUM_W'(acc_mag) << FRAC_SHIFT) + NUM_W'(wsum_q);
  assign div_req.den   = {wsum_q, 1'b0};

  cma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---- output register ----------------------------------------------------
  logic [AVG_W-1:0] quot_lo;
  assign quot_lo = div_rsp.quot[AVG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (emit_load) out_valid_q <= 1'b1;
      else if (out_chan_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      avg_q      <= neg_q ? $signed(AVG_W'(0) - quot_lo) : $signed(quot_lo);
      last_out_q <= last_q && (d_q == '0);
    end
  end

  assign out_chan_o.valid    = out_valid_q;
  assign out_chan_o.average  = avg_q;
  assign out_chan_o.last_out = last_out_q;

  // ---- assertions ---------------------------------------------------------
  `CMA_ASSERT_IMP(a_slot_in_ring, clk_i, rst_ni, state_q == ST_MAC,
                  slot_q < SLOT_W'(RING_DEPTH), "ring slot out of range")
  `CMA_ASSERT_IMP(a_wsum_nonzero, clk_i, rst_ni, state_q == ST_DIV_LOAD,
                  wsum_q != '0, "zero weight sum at divide")
  `CMA_ASSERT_IMP(a_pos_in_record, clk_i, rst_ni, state_q == ST_SETUP,
                  CNT_W'(d_q) <= cur_q, "position before record start")
  `CMA_ASSERT_NXT(a_div_done_in_div, clk_i, rst_ni, state_q == ST_DIV_LOAD,
                  !div_rsp.done && state_q == ST_DIV, "divider timing slip")

endmodule

`default_nettype wire

@@ verif/cma_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cma_checker
// Watches the sample, result and register channels of the moving average
// block. It keeps its own ring of samples and register copies, works out
// every average that an accepted sample causes, and compares each result
// item that comes out with the oldest one still waiting.
// ---------------------------------------------------------------------------

module cma_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [cma_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 last_in_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic        [cma_pkg::AVG_W-1:0]     average_i,
  input  logic                                 last_out_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic        [cma_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [cma_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   checked_o
);
  import cma_pkg::*;

  localparam logic [HW_W-1:0] HALF_WIDTH_RESET = 5'd2;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             last_out;
  } avg_result_t;

  avg_result_t                expected_avgs [$];
  logic signed [SAMPLE_W-1:0] window_ring [RING_DEPTH];
  logic        [HW_W-1:0]     half_width_r;
  logic                       weighted_r;
  int unsigned                seen_n;
  int unsigned                wr_slot;
  int                         n_fail    = 0;
  int                         n_checked = 0;

  // Average of the position lying d back from the newest sample (ring slot
  // newest, record index cur), window cut at both record ends.
  function automatic logic [AVG_W-1:0] centred_average(input int unsigned newest,
                                                       input int unsigned cur,
                                                       input int unsigned d,
                                                       input int unsigned h);
    int unsigned pos, left, right, back, slot, offs;
    longint      acc, wsum, w, mag, q;
    bit          neg;
    int          k;
    pos   = cur - d;
    left  = (pos < h) ? pos : h;
    right = (d < h) ? d : h;
    acc   = 0;
    wsum  = 0;
    for (k = -int'(left); k <= int'(right); k++) begin
      back = int'(d) - k;
      slot = (newest + RING_DEPTH - back) % RING_DEPTH;
      offs = (k < 0) ? -k : k;
      w    = weighted_r ? longint'(h + 1 - offs) : 64'sd1;
      acc  += w * longint'(window_ring[slot]);
      wsum += w;
    end
    // 8 fraction bits, halves rounded away from zero
    neg = acc < 0;
    mag = (neg ? -acc : acc) * 256;
    q   = (2 * mag + wsum) / (2 * wsum);
    q   = neg ? -q : q;
    return q[AVG_W-1:0];
  endfunction

  task automatic predict_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int unsigned h, newest, cur, d;
    avg_result_t r;
    h      = (half_width_r > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : half_width_r;
    newest = wr_slot;
    cur    = seen_n;
    window_ring[newest] = s;
    if (cur >= h) begin
      r.average  = centred_average(newest, cur, h, h);
      r.last_out = last && (h == 0);
      expected_avgs.push_back(r);
    end
    if (last) begin
      // flush the outstanding positions, oldest first
      d = h;
      while (d > 0) begin
        d--;
        if (d <= cur) begin
          r.average  = centred_average(newest, cur, d, h);
          r.last_out = (d == 0);
          expected_avgs.push_back(r);
        end
      end
      seen_n  = 0;
      wr_slot = 0;
    end else begin
      seen_n  = (cur + 1 > RING_DEPTH) ? RING_DEPTH : cur + 1;
      wr_slot = (newest + 1) % RING_DEPTH;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    avg_result_t want;
    if (!rst_ni) begin
      half_width_r = HALF_WIDTH_RESET;
      weighted_r   = 1'b0;
      seen_n       = 0;
      wr_slot      = 0;
      expected_avgs.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_avgs.size() == 0) begin
          $display("%0t cma_checker: unexpected result, expected none got %0d last %0b",
                   $time, $signed(average_i), last_out_i);
          n_fail++;
        end else begin
          want = expected_avgs.pop_front();
          n_checked++;
          if (average_i !== want.average) begin
            $display("%0t cma_checker: average mismatch, expected %0d got %0d",
                     $time, $signed(want.average), $signed(average_i));
            n_fail++;
          end
          if (last_out_i !== want.last_out) begin
            $display("%0t cma_checker: last_out mismatch, expected %0b got %0b",
                     $time, want.last_out, last_out_i);
            n_fail++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_HALF_WIDTH: begin
            half_width_r = cfg_data_i[HW_W-1:0];
            seen_n       = 0;
            wr_slot      = 0;
          end
          CFG_WEIGHTED_MODE: begin
            weighted_r = cfg_data_i[0];
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_sample(sample_i, last_in_i);
      end
    end
    fail_count_o <= n_fail;
    pending_o    <= expected_avgs.size();
    checked_o    <= n_checked;
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the centered moving average block: a directed
// set of records at the field and register extremes, then random records
// over many register settings, with random stalls on both channels.
// ---------------------------------------------------------------------------

module tb_top;
  import cma_pkg::*;

  localparam int          RANDOM_ITEMS  = 450;
  localparam int          CALM_ITEMS    = 80;         // final stretch, no idling
  localparam int          SETTLE_CYCLES = 100;        // > one 33-entry pass + divide
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  // index that names no register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'hF;

  logic        clk_i;
  logic        rst_ni;
  int          fail_count;
  int          pending;
  int          checked;
  int          n_items   = 0;
  int          n_records = 0;
  int          n_writes  = 0;
  int unsigned cycles    = 0;
  bit          calm      = 1'b0;

  cma_in_if  in_if ();
  cma_out_if out_if ();
  cma_cfg_if cfg_if ();

  centered_moving_average dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .out_chan_o (out_if),
    .cfg_chan_i (cfg_if)
  );

  cma_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .sample_i     (in_if.sample),
    .last_in_i    (in_if.last_in),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .average_i    (out_if.average),
    .last_out_i   (out_if.last_out),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_index_i  (cfg_if.index),
    .cfg_data_i   (cfg_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 8 ns clock, low phase first, first rising edge at 4 ns
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t tb_top: timed out, %0d averages outstanding", $time, pending);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Result side: ready held high in runs of random length, broken by stall
  // bursts; the occasional long run gives stall-free stretches.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_if.ready = 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 150 : 25)) @(negedge clk_i);
      if (!calm) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
    end
  end

  // Full-scale values and values near zero turn up more often than a flat
  // draw would give them.
  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SAMPLE_W'($urandom_range(0, 16)) - 16'd8;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Offer one sample item and wait for it to be taken. Entered and left at a
  // falling edge. Valid stays high on exit so that back-to-back items need
  // no fresh rising edge on it; anything that waits for other reasons drops it.
  task automatic put_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.sample  = s;
    in_if.last_in = last;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    n_items++;
    if (last) n_records++;
  endtask

  // Block is idle once every predicted average is out and it has had time
  // to finish anything that yields no result.
  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register writes only ever happen with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    n_writes++;
  endtask

  initial begin
    logic [HW_W-1:0]       hw;
    logic [CFG_DATA_W-1:0] d;
    int                    r, len, cut, eff, i, first_random;

    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    in_if.last_in = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    rst_ni        = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed part -------------------------------------------------
    // Reset settings (half width 2, equal weights), full-scale neighbours.
    put_sample(16'sh7FFF, 1'b0);
    put_sample(16'sh8000, 1'b0);
    put_sample(16'sh0000, 1'b0);
    put_sample(16'sh0001, 1'b0);
    put_sample(16'shFFFF, 1'b1);

    // Zero half width: every sample comes straight back. Upper data bits set
    // and ignored.
    write_reg(CFG_HALF_WIDTH, 8'hE0);
    put_sample(16'sh7FFF, 1'b0);
    put_sample(16'sh8000, 1'b1);

    // Records shorter than the half width: all results on the last item.
    write_reg(CFG_HALF_WIDTH, 8'h03);
    write_reg(CFG_WEIGHTED_MODE, 8'hFF);
    put_sample(16'sh8000, 1'b0);
    put_sample(16'sh7FFF, 1'b1);
    put_sample(16'sh3039, 1'b1);

    // Half width above the limit acts as the limit; lowest average.
    write_reg(CFG_HALF_WIDTH, 8'h1F);
    put_sample(16'sh8000, 1'b0);
    put_sample(16'sh8000, 1'b0);
    put_sample(16'sh8000, 1'b0);
    put_sample(16'sh8000, 1'b1);

    // Largest legal half width; highest average.
    write_reg(CFG_HALF_WIDTH, 8'h10);
    put_sample(16'sh7FFF, 1'b0);
    put_sample(16'sh7FFF, 1'b0);
    put_sample(16'sh7FFF, 1'b1);

    // Half width rewritten mid-record: the open record is dropped. Then an
    // unused index, then a weight mode switch in the middle of a record.
    write_reg(CFG_HALF_WIDTH, 8'h02);
    write_reg(CFG_WEIGHTED_MODE, 8'h00);
    put_sample(16'sh7FFF, 1'b0);
    put_sample(16'sh0100, 1'b0);
    put_sample(16'sh8000, 1'b0);
    put_sample(16'sh0005, 1'b0);
    write_reg(CFG_HALF_WIDTH, 8'h01);
    write_reg(CFG_UNUSED_IDX, 8'hFF);
    put_sample(16'sh0064, 1'b0);
    put_sample(-16'sh0064, 1'b0);
    write_reg(CFG_WEIGHTED_MODE, 8'h01);
    put_sample(16'sh0007, 1'b1);

    // ---- random part ---------------------------------------------------
    // Each phase picks a setting, then sends one to three records. Most are
    // plain records of random length, some run past the ring depth, a few
    // switch weights part way through or are cut short by a half width rewrite.
    first_random = n_items;
    while (n_items - first_random < RANDOM_ITEMS) begin
      r = $urandom_range(0, 15);
      if (r == 0)     hw = 5'd0;
      else if (r == 1) hw = 5'd16;
      else if (r == 2) hw = HW_W'($urandom_range(17, 31));
      else if (r < 6)  hw = HW_W'($urandom_range(7, 15));
      else             hw = HW_W'($urandom_range(1, 6));
      d = CFG_DATA_W'($urandom());
      d[HW_W-1:0] = hw;
      write_reg(CFG_HALF_WIDTH, d);
      write_reg(CFG_WEIGHTED_MODE, CFG_DATA_W'($urandom()));
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom()));
      end
      eff = (hw > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : hw;

      repeat ($urandom_range(1, 3)) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(34, 50)
                                          : $urandom_range(1, 2 * eff + 4);
        cut = $urandom_range(1, len);
        r   = $urandom_range(0, 7);
        if (r == 1) begin
          // broken record: dropped by a half width rewrite
          for (i = 0; i < cut; i++) put_sample(draw_sample(), 1'b0);
          d = CFG_DATA_W'($urandom());
          d[HW_W-1:0] = hw;
          write_reg(CFG_HALF_WIDTH, d);
        end else begin
          for (i = 0; i < len; i++) begin
            if (r == 0 && i == cut - 1) write_reg(CFG_WEIGHTED_MODE, CFG_DATA_W'($urandom()));
            put_sample(draw_sample(), i == len - 1);
          end
        end
        if (n_items - first_random >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      end
    end

    // ---- drain and verdict ---------------------------------------------
    wait_idle();
    $display("tb_top: %0d sample items in %0d records, %0d averages checked",
             n_items, n_records, checked);
    $display("tb_top: %0d register writes over half widths 0..31 and both weightings",
             n_writes);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/cma_pkg.sv
hw/rtl/cma_in_if.sv
hw/rtl/cma_out_if.sv
hw/rtl/cma_cfg_if.sv
hw/rtl/cma_div.sv
hw/rtl/centered_moving_average.sv
verif/cma_checker.sv
verif/tb_top.sv
